### src/slph_pkg.sv
// Shared types and constants for the serial link ping handshake unit.
// No dependencies; imported by slph_step and serial_link_ping_handshake_unit.
package slph_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned TAG_W = 4;
  localparam int unsigned PH_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Link phase codes; codes five to seven are unreachable and held.
  localparam logic [PH_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PH_W-1:0] PH_WAIT0 = 3'd1;
  localparam logic [PH_W-1:0] PH_WAIT1 = 3'd2;
  localparam logic [PH_W-1:0] PH_EXTRA = 3'd3;
  localparam logic [PH_W-1:0] PH_OPER  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IS_MASTER       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANDSHAKE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT     = 2'd2;

  localparam logic [CNT_W-1:0] HANDSHAKE_LIMIT_RST = 16'd1000;
  localparam logic [CNT_W-1:0] RETRY_LIMIT_RST     = 16'd200;
  localparam logic [CNT_W-1:0] CNT_MAX             = 16'hFFFF;

  localparam logic [TAG_W-1:0] TAG_ZERO = 4'd0;
  localparam logic [TAG_W-1:0] TAG_ONE  = 4'd1;

  typedef struct packed {
    logic             is_master;
    logic [CNT_W-1:0] handshake_limit;
    logic [CNT_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic             ping_seen;
    logic [TAG_W-1:0] rx_tag;
    logic             watchdog_expired;
    logic             core_error;
  } beat_in_t;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [CNT_W-1:0] overall_ticks;
    logic [CNT_W-1:0] phase_ticks;
  } link_st_t;

  typedef struct packed {
    logic [PH_W-1:0] link_state;
    logic            tx_ping;
    logic            ping_tag;
    logic            flush_tx;
    logic            to_software_mode;
    logic            to_ping_mode;
    logic            reset_rx_core;
    logic            link_up;
  } beat_out_t;

endpackage

### src/slph_step.sv
// Next-state and command logic for one tick of the link handshake.
// Depends on slph_pkg for the phase codes and the beat and state structs.
module slph_step (
  input  slph_pkg::cfg_t      cfg,
  input  slph_pkg::link_st_t  st,
  input  slph_pkg::beat_in_t  beat,
  output slph_pkg::link_st_t  st_next,
  output slph_pkg::beat_out_t res
);
  import slph_pkg::*;

  logic [CNT_W-1:0] overall_inc;
  logic [CNT_W-1:0] phase_inc;
  logic             over;
  logic             retry;
  logic             tag0_hit;
  logic             tag1_hit;

  // Saturating increments, compared after the increment
  assign overall_inc = (st.overall_ticks == CNT_MAX) ? CNT_MAX : st.overall_ticks + 1'b1;
  assign phase_inc   = (st.phase_ticks == CNT_MAX) ? CNT_MAX : st.phase_ticks + 1'b1;
  assign over        = overall_inc > cfg.handshake_limit;
  assign retry       = phase_inc > cfg.retry_limit;
  assign tag0_hit    = beat.ping_seen && (beat.rx_tag == TAG_ZERO);
  assign tag1_hit    = beat.ping_seen && (beat.rx_tag == TAG_ONE);

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (st.phase)
      PH_IDLE: begin
        res.to_software_mode = 1'b1;
        if (cfg.is_master) begin
          res.flush_tx = 1'b1;
          res.tx_ping  = 1'b1;
        end
        st_next.phase         = PH_WAIT0;
        st_next.overall_ticks = '0;
        st_next.phase_ticks   = '0;
      end
      PH_WAIT0: begin
        st_next.overall_ticks = overall_inc;
        st_next.phase_ticks   = phase_inc;
        if (over || retry) begin
          st_next.phase = PH_IDLE;
        end else if (tag0_hit) begin
          res.tx_ping         = 1'b1;
          res.ping_tag        = cfg.is_master;
          res.flush_tx        = !cfg.is_master;
          st_next.phase       = PH_WAIT1;
          st_next.phase_ticks = '0;
        end
      end
      PH_WAIT1: begin
        st_next.overall_ticks = overall_inc;
        st_next.phase_ticks   = phase_inc;
        if (over) begin
          st_next.phase = PH_IDLE;
        end else if (retry) begin
          // resend the same tag as on entry
          res.tx_ping         = 1'b1;
          res.ping_tag        = cfg.is_master;
          res.flush_tx        = !cfg.is_master;
          st_next.phase_ticks = '0;
        end else if (tag1_hit) begin
          res.to_ping_mode = 1'b1;
          if (cfg.is_master) begin
            st_next.phase = PH_OPER;
          end else begin
            res.tx_ping   = 1'b1;
            res.ping_tag  = 1'b1;
            st_next.phase = PH_EXTRA;
          end
        end
      end
      PH_EXTRA: begin
        // a master here has no action: hold state and counters
        if (!cfg.is_master) begin
          st_next.overall_ticks = overall_inc;
          st_next.phase_ticks   = phase_inc;
          st_next.phase         = PH_OPER;
        end
      end
      PH_OPER: begin
        if (beat.watchdog_expired) begin
          st_next.phase = PH_IDLE;
        end else if (beat.core_error) begin
          res.reset_rx_core = 1'b1;
          st_next.phase     = PH_IDLE;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
    res.link_state = st_next.phase;
    res.link_up    = (st_next.phase == PH_OPER);
  end

endmodule

### src/serial_link_ping_handshake_unit.sv
// Top level of the serial link ping handshake unit: input register, config
// registers, link state and result register. Depends on slph_pkg, slph_step.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | in_valid/in_ready  | ping_seen, rx_tag, watchdog_expired,
//          |                    | core_error
//  output  | out_valid/out_ready| link_state, tx_ping, ping_tag, flush_tx,
//          |                    | to_software_mode, to_ping_mode,
//          |                    | reset_rx_core, link_up
//  config  | cfg_we             | cfg_index, cfg_data
//
// One tick a cycle sustained without output stalls; a result is registered
// from its beat (input, then result register). The step logic between
// them is a 16-bit increment and compare per counter plus the phase select.
// Reset puts the link in idle with both counters zero and the config at its
// defaults. A stalled output holds the result register and, once the input
// register is also full, drops in_ready; nothing is lost or repeated.
module serial_link_ping_handshake_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            ping_seen,
  input  logic [slph_pkg::TAG_W-1:0]      rx_tag,
  input  logic                            watchdog_expired,
  input  logic                            core_error,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [slph_pkg::PH_W-1:0]       link_state,
  output logic                            tx_ping,
  output logic                            ping_tag,
  output logic                            flush_tx,
  output logic                            to_software_mode,
  output logic                            to_ping_mode,
  output logic                            reset_rx_core,
  output logic                            link_up,
  input  logic                            cfg_we,
  input  logic [slph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slph_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slph_pkg::*;

  cfg_t      cfg;
  link_st_t  st;
  link_st_t  st_next;
  beat_in_t  in_beat;
  logic      in_full;
  beat_out_t res_next;
  beat_out_t res;
  logic      advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_master       <= 1'b0;
      cfg.handshake_limit <= HANDSHAKE_LIMIT_RST;
      cfg.retry_limit     <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IS_MASTER:       cfg.is_master       <= cfg_data[0];
        REG_HANDSHAKE_LIMIT: cfg.handshake_limit <= cfg_data;
        REG_RETRY_LIMIT:     cfg.retry_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_beat <= '{ping_seen, rx_tag, watchdog_expired, core_error};
    end
  end

  slph_step u_step (
    .cfg     (cfg),
    .st      (st),
    .beat    (in_beat),
    .st_next (st_next),
    .res     (res_next)
  );

  // Link state and result register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_IDLE;
      st.overall_ticks <= '0;
      st.phase_ticks   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign link_state       = res.link_state;
  assign tx_ping          = res.tx_ping;
  assign ping_tag         = res.ping_tag;
  assign flush_tx         = res.flush_tx;
  assign to_software_mode = res.to_software_mode;
  assign to_ping_mode     = res.to_ping_mode;
  assign reset_rx_core    = res.reset_rx_core;
  assign link_up          = res.link_up;

  a_tag_needs_ping: assert property (@(posedge clk) disable iff (rst)
    out_valid && ping_tag |-> tx_ping)
    else $error("ping_tag set without tx_ping");

  a_swmode_enters_wait0: assert property (@(posedge clk) disable iff (rst)
    out_valid && to_software_mode |-> link_state == PH_WAIT0)
    else $error("software mode pulse outside idle exit");

  a_rxreset_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_rx_core |-> link_state == PH_IDLE && !link_up)
    else $error("receiver reset without drop to idle");

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_state_tracks_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> st.phase == link_state)
    else $error("link state and result disagree");

endmodule
